@@ sv/ttad_pkg.sv @@
// Shared types and constants for the teletext attribute decoder.
// Used by ttad_cell, teletext_attribute_decoder_core and the testbench; depends on nothing.

package ttad_pkg;

	localparam int CODE_W = 7;

	// Control codes below the printable range
	localparam logic [CODE_W-1:0] CTL_ALPHA_LO  = 7'd1;
	localparam logic [CODE_W-1:0] CTL_ALPHA_HI  = 7'd7;
	localparam logic [CODE_W-1:0] CTL_FLASH     = 7'd8;
	localparam logic [CODE_W-1:0] CTL_STEADY    = 7'd9;
	localparam logic [CODE_W-1:0] CTL_NORMAL_HT = 7'd12;
	localparam logic [CODE_W-1:0] CTL_DOUBLE_HT = 7'd13;
	localparam logic [CODE_W-1:0] CTL_MOSAIC_LO = 7'd17;
	localparam logic [CODE_W-1:0] CTL_MOSAIC_HI = 7'd23;
	localparam logic [CODE_W-1:0] CTL_CONTIG    = 7'd25;
	localparam logic [CODE_W-1:0] CTL_SEPARATED = 7'd26;
	localparam logic [CODE_W-1:0] CTL_BLACK_BG  = 7'd28;
	localparam logic [CODE_W-1:0] CTL_NEW_BG    = 7'd29;
	localparam logic [CODE_W-1:0] CTL_HOLD      = 7'd30;
	localparam logic [CODE_W-1:0] CTL_RELEASE   = 7'd31;

	localparam logic [CODE_W-1:0] CODE_BLANK = 7'd0;
	localparam logic [CODE_W-1:0] CODE_SPACE = 7'd32;

	localparam logic [1:0] GSET_ALPHA     = 2'd0;
	localparam logic [1:0] GSET_CONTIG    = 2'd1;
	localparam logic [1:0] GSET_SEPARATED = 2'd2;

	localparam logic [1:0] HEIGHT_STD   = 2'd0;
	localparam logic [1:0] HEIGHT_UPPER = 2'd1;
	localparam logic [1:0] HEIGHT_LOWER = 2'd2;

	localparam logic [2:0] COLOUR_WHITE = 3'd7;
	localparam logic [2:0] COLOUR_BLACK = 3'd0;

	typedef struct packed {
		logic [2:0]        fore;
		logic [2:0]        back;
		logic              mosaic;
		logic              separated;
		logic              hold;
		logic [CODE_W-1:0] held;
		logic              dbl;
		logic              flash;
		logic              next_bottom;
		logic              row_bottom;
	} attr_t;

	localparam attr_t ATTR_RESET = '{
		fore:        COLOUR_WHITE,
		back:        COLOUR_BLACK,
		mosaic:      1'b0,
		separated:   1'b0,
		hold:        1'b0,
		held:        CODE_BLANK,
		dbl:         1'b0,
		flash:       1'b0,
		next_bottom: 1'b0,
		row_bottom:  1'b0
	};

	typedef struct packed {
		logic [CODE_W-1:0] glyph_code;
		logic [1:0]        glyph_set;
		logic [1:0]        height_part;
		logic              cell_blank;
		logic [2:0]        fore_colour;
		logic [2:0]        back_colour;
	} cell_out_t;

endpackage

@@ sv/ttad_cell.sv @@
// Per-cell attribute update and glyph selection, purely combinational.
// Uses ttad_pkg for the attribute and result structs and the control codes.

module ttad_cell (
	input  ttad_pkg::attr_t     attr,
	input  logic [7:0]          char_code,
	input  logic                first_in_row,
	input  logic                first_in_page,
	input  logic                flash_visible,
	output ttad_pkg::attr_t     attr_next,
	output ttad_pkg::cell_out_t res
);

	always_comb begin
		ttad_pkg::attr_t                  a;
		logic [ttad_pkg::CODE_W-1:0]      c;
		logic                             blank;

		a = attr;
		c = char_code[ttad_pkg::CODE_W-1:0];

		// Row start: latch the bottom-row flag, then reset the row attributes
		if (first_in_row || first_in_page) begin
			a = ttad_pkg::ATTR_RESET;
			a.row_bottom = attr.next_bottom;
		end
		if (first_in_page) begin
			a.row_bottom  = 1'b0;
			a.next_bottom = 1'b0;
		end

		if (c < ttad_pkg::CODE_SPACE) begin
			case (c) inside
				[ttad_pkg::CTL_ALPHA_LO:ttad_pkg::CTL_ALPHA_HI]: begin
					a.fore   = c[2:0];
					a.mosaic = 1'b0;
				end
				[ttad_pkg::CTL_MOSAIC_LO:ttad_pkg::CTL_MOSAIC_HI]: begin
					a.fore   = c[2:0];
					a.mosaic = 1'b1;
				end
				ttad_pkg::CTL_FLASH:     a.flash = 1'b1;
				ttad_pkg::CTL_STEADY:    a.flash = 1'b0;
				ttad_pkg::CTL_NORMAL_HT: a.dbl = 1'b0;
				ttad_pkg::CTL_DOUBLE_HT: begin
					a.dbl = 1'b1;
					if (!a.row_bottom)
						a.next_bottom = 1'b1;
				end
				ttad_pkg::CTL_CONTIG:    a.separated = 1'b0;
				ttad_pkg::CTL_SEPARATED: a.separated = 1'b1;
				ttad_pkg::CTL_BLACK_BG:  a.back = ttad_pkg::COLOUR_BLACK;
				ttad_pkg::CTL_NEW_BG:    a.back = a.fore;
				ttad_pkg::CTL_HOLD:      a.hold = 1'b1;
				ttad_pkg::CTL_RELEASE:   a.hold = 1'b0;
				default: ;
			endcase
			// Control cell shows the held mosaic or nothing
			c = (a.hold && a.mosaic) ? a.held : ttad_pkg::CODE_BLANK;
		end

		blank = !a.dbl && a.row_bottom;

		res.height_part = a.dbl ? (a.row_bottom ? ttad_pkg::HEIGHT_LOWER
		                                        : ttad_pkg::HEIGHT_UPPER)
		                        : ttad_pkg::HEIGHT_STD;
		res.cell_blank  = blank;
		res.glyph_set   = a.mosaic ? (a.separated ? ttad_pkg::GSET_SEPARATED
		                                          : ttad_pkg::GSET_CONTIG)
		                           : ttad_pkg::GSET_ALPHA;

		// Capture before flash and blanking hide the cell
		if (a.mosaic && c[5])
			a.held = c;

		if (a.flash && !flash_visible)
			c = ttad_pkg::CODE_SPACE;
		if (blank)
			c = ttad_pkg::CODE_BLANK;

		res.glyph_code  = c;
		res.fore_colour = a.fore;
		res.back_colour = a.back;
		attr_next       = a;
	end

endmodule

@@ sv/teletext_attribute_decoder_core.sv @@
// Teletext serial attribute decoder: one character cell in, one draw item out.
// Uses ttad_pkg and instantiates ttad_cell.

// The block takes one character item per clock and gives one result item per
// clock for as long as the output side keeps taking them. An accepted item is
// held in the input register, then its result is loaded into the output
// register, from which it is offered; a stalled output holds both registers.
// The rate is one item per cycle while the output keeps taking items, set by
// the row attribute register, which is read and updated by the cell decoder
// once per item. cfg_ready is always high; flash_visible takes effect from the
// next item decoded.

module teletext_attribute_decoder_core (
	input  logic       clk,
	input  logic       arst_n,

	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,

	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       first_in_row,
	input  logic       first_in_page,

	output logic       out_valid,
	input  logic       out_ready,
	output logic [6:0] glyph_code,
	output logic [1:0] glyph_set,
	output logic [1:0] height_part,
	output logic       cell_blank,
	output logic [2:0] fore_colour,
	output logic [2:0] back_colour
);

	logic                flash_visible_q;
	ttad_pkg::attr_t     attr_q;
	ttad_pkg::attr_t     attr_next;
	ttad_pkg::cell_out_t cell_res;
	ttad_pkg::cell_out_t cell_s2;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       row_s1;
	logic       page_s1;
	logic       advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_visible_q <= 1'b1;
		end else if (cfg_valid) begin
			flash_visible_q <= cfg_data;
		end
	end

	// Move the item on when the output register is free or being drained
	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_code;
			row_s1  <= first_in_row;
			page_s1 <= first_in_page;
		end
	end

	ttad_cell u_cell (
		.attr          (attr_q),
		.char_code     (char_s1),
		.first_in_row  (row_s1),
		.first_in_page (page_s1),
		.flash_visible (flash_visible_q),
		.attr_next     (attr_next),
		.res           (cell_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q    <= ttad_pkg::ATTR_RESET;
			out_valid <= 1'b0;
		end else begin
			if (advance)
				attr_q <= attr_next;
			if (advance)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			cell_s2 <= cell_res;
	end

	assign glyph_code  = cell_s2.glyph_code;
	assign glyph_set   = cell_s2.glyph_set;
	assign height_part = cell_s2.height_part;
	assign cell_blank  = cell_s2.cell_blank;
	assign fore_colour = cell_s2.fore_colour;
	assign back_colour = cell_s2.back_colour;

	// Blanked cells carry no glyph and are never double height
	a_blank_cell: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cell_blank |->
			glyph_code == ttad_pkg::CODE_BLANK && height_part == ttad_pkg::HEIGHT_STD)
		else $error("blanked cell carries a glyph or a double-height part");

	// Only a mosaic code with bit 5 set is ever held
	a_held_code: assert property (@(posedge clk) disable iff (!arst_n)
		attr_q.held == ttad_pkg::CODE_BLANK || attr_q.held[5])
		else $error("held mosaic register holds a non-mosaic code");

	// A stalled output keeps the waiting item in the input register
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid && !out_ready |=> valid_s1 && $stable(attr_q))
		else $error("item or attributes lost while output stalled");

	// The bottom-row flag never arms a further bottom row
	a_bottom_chain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(attr_q.next_bottom) |-> !attr_q.row_bottom)
		else $error("double height on a bottom row armed the next row");

endmodule

@@ tb/tb_teletext_attribute_decoder_core.sv @@
// Self-checking testbench for teletext_attribute_decoder_core.
// Drives character cells through a valid/ready driver, predicts each draw item
// with its own attribute model and checks results in order; uses ttad_pkg.
`timescale 1ns / 100ps

module tb_teletext_attribute_decoder_core;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_CELLS  = 75;
	localparam int PHASES        = 8;
	localparam int IDLE_PCT      = 63;
	localparam int BOTH_IDLE_PCT = 26;

	typedef struct {
		logic [7:0] code;
		logic       row;
		logic       page;
	} cell_in_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_data = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] char_code = 8'd0;
	logic       first_in_row = 1'b0;
	logic       first_in_page = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [6:0] glyph_code;
	logic [1:0] glyph_set;
	logic [1:0] height_part;
	logic       cell_blank;
	logic [2:0] fore_colour;
	logic [2:0] back_colour;

	cell_in_t            pending_cells[$];
	ttad_pkg::cell_out_t cell_expect[$];
	ttad_pkg::attr_t     row_attr = ttad_pkg::ATTR_RESET;
	logic                flash_shown = 1'b1;
	int                  send_idle_pct = 0;
	int                  recv_stall_pct = 0;
	int                  error_count = 0;
	int                  cycle_count = 0;

	teletext_attribute_decoder_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.char_code     (char_code),
		.first_in_row  (first_in_row),
		.first_in_page (first_in_page),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.glyph_code    (glyph_code),
		.glyph_set     (glyph_set),
		.height_part   (height_part),
		.cell_blank    (cell_blank),
		.fore_colour   (fore_colour),
		.back_colour   (back_colour)
	);

	always #2 clk = ~clk;

	// Update the row attributes for one cell and work out its draw item
	function automatic ttad_pkg::cell_out_t decode_cell(input logic [7:0] raw,
			input logic row_mark, input logic page_mark);
		logic [ttad_pkg::CODE_W-1:0] c;
		logic                        bottom;
		ttad_pkg::cell_out_t         r;
		c = raw[ttad_pkg::CODE_W-1:0];
		if (row_mark || page_mark) begin
			bottom = row_attr.next_bottom;
			row_attr = ttad_pkg::ATTR_RESET;
			row_attr.row_bottom = bottom;
		end
		if (page_mark) begin
			row_attr.row_bottom = 1'b0;
			row_attr.next_bottom = 1'b0;
		end
		if (c < ttad_pkg::CODE_SPACE) begin
			if (c >= ttad_pkg::CTL_ALPHA_LO && c <= ttad_pkg::CTL_ALPHA_HI) begin
				row_attr.fore = c[2:0];
				row_attr.mosaic = 1'b0;
			end else if (c >= ttad_pkg::CTL_MOSAIC_LO && c <= ttad_pkg::CTL_MOSAIC_HI) begin
				row_attr.fore = c[2:0];
				row_attr.mosaic = 1'b1;
			end else begin
				case (c)
					ttad_pkg::CTL_FLASH:     row_attr.flash = 1'b1;
					ttad_pkg::CTL_STEADY:    row_attr.flash = 1'b0;
					ttad_pkg::CTL_NORMAL_HT: row_attr.dbl = 1'b0;
					ttad_pkg::CTL_DOUBLE_HT: begin
						row_attr.dbl = 1'b1;
						if (!row_attr.row_bottom)
							row_attr.next_bottom = 1'b1;
					end
					ttad_pkg::CTL_CONTIG:    row_attr.separated = 1'b0;
					ttad_pkg::CTL_SEPARATED: row_attr.separated = 1'b1;
					ttad_pkg::CTL_BLACK_BG:  row_attr.back = ttad_pkg::COLOUR_BLACK;
					ttad_pkg::CTL_NEW_BG:    row_attr.back = row_attr.fore;
					ttad_pkg::CTL_HOLD:      row_attr.hold = 1'b1;
					ttad_pkg::CTL_RELEASE:   row_attr.hold = 1'b0;
					default:                 ;
				endcase
			end
			c = (row_attr.hold && row_attr.mosaic) ? row_attr.held : ttad_pkg::CODE_BLANK;
		end
		r.height_part = row_attr.dbl ? (row_attr.row_bottom ? ttad_pkg::HEIGHT_LOWER
			: ttad_pkg::HEIGHT_UPPER) : ttad_pkg::HEIGHT_STD;
		r.cell_blank = !row_attr.dbl && row_attr.row_bottom;
		r.glyph_set = row_attr.mosaic ? (row_attr.separated ? ttad_pkg::GSET_SEPARATED
			: ttad_pkg::GSET_CONTIG) : ttad_pkg::GSET_ALPHA;
		// Capture before flash or blanking hides the code
		if (row_attr.mosaic && c[5])
			row_attr.held = c;
		if (row_attr.flash && !flash_shown)
			c = ttad_pkg::CODE_SPACE;
		if (r.cell_blank)
			c = ttad_pkg::CODE_BLANK;
		r.glyph_code = c;
		r.fore_colour = row_attr.fore;
		r.back_colour = row_attr.back;
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			error_count++;
		end
	endtask

	task automatic push_cell(input logic [7:0] code, input logic row, input logic page);
		cell_in_t item;
		item.code = code;
		item.row = row;
		item.page = page;
		pending_cells = {pending_cells, item};
	endtask

	function automatic logic [7:0] pick_code();
		int unsigned sel;
		logic [6:0]  low;
		sel = $urandom_range(99);
		if (sel < 5)
			low = ttad_pkg::CTL_DOUBLE_HT;
		else if (sel < 40)
			low = 7'($urandom_range(31));
		else
			low = 7'($urandom_range(127, 32));
		return {1'($urandom_range(1)), low};
	endfunction

	// Runs of up to 40 cells with a row mark on the first cell, some page marks, some noise
	task automatic queue_random_cells(input int count);
		int left;
		int run;
		int k;
		cell_in_t item;
		left = count;
		while (left > 0) begin
			run = $urandom_range(40, 1);
			if (run > left)
				run = left;
			for (k = 0; k < run; k++) begin
				item.code = pick_code();
				item.row = (k == 0);
				item.page = (k == 0) && ($urandom_range(7) == 0);
				if ($urandom_range(19) == 0) begin
					item.code = 8'($urandom_range(255));
					item.row = 1'($urandom_range(1));
					item.page = 1'($urandom_range(1));
				end
				pending_cells = {pending_cells, item};
			end
			left -= run;
		end
	endtask

	task automatic wait_drained();
		while (pending_cells.size() != 0 || in_valid || cell_expect.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_flash(input logic value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		flash_shown = value;
		cfg_valid <= 1'b0;
	endtask

	// Driver: hold each item until accepted, predict it at acceptance
	always @(posedge clk) begin
		cell_in_t item;
		if (arst_n) begin
			if (in_valid && in_ready)
				cell_expect = {cell_expect,
					decode_cell(char_code, first_in_row, first_in_page)};
			if (!in_valid || in_ready) begin
				if (pending_cells.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					item = pending_cells.pop_front();
					char_code <= item.code;
					first_in_row <= item.row;
					first_in_page <= item.page;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		ttad_pkg::cell_out_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (cell_expect.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual glyph %0d",
						$time, glyph_code);
					error_count++;
				end else begin
					want = cell_expect.pop_front();
					check_field("glyph_code", 32'(want.glyph_code), 32'(glyph_code));
					check_field("glyph_set", 32'(want.glyph_set), 32'(glyph_set));
					check_field("height_part", 32'(want.height_part), 32'(height_part));
					check_field("cell_blank", 32'(want.cell_blank), 32'(cell_blank));
					check_field("fore_colour", 32'(want.fore_colour), 32'(fore_colour));
					check_field("back_colour", 32'(want.back_colour), 32'(back_colour));
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int p;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		write_flash(1'b1);
		@(negedge clk);
		push_cell(8'h41, 1'b1, 1'b1);
		push_cell(8'hFF, 1'b0, 1'b0);
		push_cell(8'(ttad_pkg::CODE_BLANK), 1'b0, 1'b0);
		push_cell(8'(ttad_pkg::CTL_ALPHA_LO), 1'b0, 1'b0);
		push_cell(8'h42, 1'b0, 1'b0);
		push_cell(8'(ttad_pkg::CTL_MOSAIC_HI), 1'b0, 1'b0);
		push_cell(8'h7F, 1'b0, 1'b0);
		push_cell(8'(ttad_pkg::CTL_SEPARATED), 1'b0, 1'b0);
		push_cell(8'h35, 1'b0, 1'b0);
		push_cell(8'(ttad_pkg::CTL_HOLD), 1'b0, 1'b0);
		push_cell(8'(ttad_pkg::CTL_BLACK_BG), 1'b0, 1'b0);
		push_cell(8'(ttad_pkg::CTL_NEW_BG), 1'b0, 1'b0);
		push_cell(8'(ttad_pkg::CTL_CONTIG), 1'b0, 1'b0);
		push_cell(8'(ttad_pkg::CTL_RELEASE), 1'b0, 1'b0);
		push_cell(8'(ttad_pkg::CTL_FLASH), 1'b0, 1'b0);
		push_cell(8'h43, 1'b0, 1'b0);
		push_cell(8'(ttad_pkg::CTL_STEADY), 1'b0, 1'b0);
		push_cell(8'(ttad_pkg::CTL_DOUBLE_HT), 1'b0, 1'b0);
		push_cell(8'(ttad_pkg::CTL_NORMAL_HT), 1'b0, 1'b0);
		// bottom row: single height blanked, double height must not latch again
		push_cell(8'h45, 1'b1, 1'b0);
		push_cell(8'(ttad_pkg::CTL_DOUBLE_HT), 1'b0, 1'b0);
		push_cell(8'h46, 1'b0, 1'b0);
		push_cell(8'h47, 1'b1, 1'b0);
		wait_drained();

		write_flash(1'b0);
		@(negedge clk);
		push_cell(8'(ttad_pkg::CTL_FLASH), 1'b1, 1'b1);
		push_cell(8'hC8, 1'b0, 1'b0);
		wait_drained();

		for (p = 0; p < PHASES; p++) begin
			write_flash(1'((p ^ (p >> 2)) & 1));
			@(negedge clk);
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = IDLE_PCT;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = IDLE_PCT;
				end
				default: begin
					send_idle_pct = BOTH_IDLE_PCT;
					recv_stall_pct = BOTH_IDLE_PCT;
				end
			endcase
			queue_random_cells(RANDOM_CELLS);
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/ttad_pkg.sv
sv/ttad_cell.sv
sv/teletext_attribute_decoder_core.sv
tb/tb_teletext_attribute_decoder_core.sv
